// ----- src/dcl_pkg.sv -----
// Shared constants, types and the control store of the divisor counter.
package dcl_pkg;

  localparam int NUMBER_WIDTH = 40;
  localparam int COUNT_W = 14;
  localparam int PROD_W = COUNT_W + 1;
  localparam int EXP_W = $clog2(NUMBER_WIDTH + 1);
  localparam int MUL_W = PROD_W + EXP_W;
  localparam int CNT_W = $clog2(NUMBER_WIDTH + 1);
  localparam int PC_W = 4;

  localparam logic [PROD_W-1:0] PROD_CAP = PROD_W'(1) << COUNT_W;

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_DIV,
    OP_STRIP,
    OP_SCALE,
    OP_ADV,
    OP_FINAL,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_DIV_BUSY,
    C_BEYOND,
    C_REM_NZ,
    C_REM_Z,
    C_OUT_FULL
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } uword_t;

  localparam pc_t PC_WAIT   = 4'd0;
  localparam pc_t PC_DSTART = 4'd1;
  localparam pc_t PC_DWAIT  = 4'd2;
  localparam pc_t PC_CHECK  = 4'd3;
  localparam pc_t PC_TEST   = 4'd4;
  localparam pc_t PC_STRIP  = 4'd5;
  localparam pc_t PC_SSTART = 4'd6;
  localparam pc_t PC_SWAIT  = 4'd7;
  localparam pc_t PC_STEST  = 4'd8;
  localparam pc_t PC_SCALE  = 4'd9;
  localparam pc_t PC_ADV    = 4'd10;
  localparam pc_t PC_FINAL  = 4'd11;
  localparam pc_t PC_EMIT   = 4'd15;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      PC_WAIT:   w = '{OP_LOAD,  C_NO_IN,    PC_WAIT};
      PC_DSTART: w = '{OP_DIV,   C_NEVER,    PC_WAIT};
      PC_DWAIT:  w = '{OP_NOP,   C_DIV_BUSY, PC_DWAIT};
      PC_CHECK:  w = '{OP_NOP,   C_BEYOND,   PC_FINAL};
      PC_TEST:   w = '{OP_NOP,   C_REM_NZ,   PC_SCALE};
      PC_STRIP:  w = '{OP_STRIP, C_NEVER,    PC_WAIT};
      PC_SSTART: w = '{OP_DIV,   C_NEVER,    PC_WAIT};
      PC_SWAIT:  w = '{OP_NOP,   C_DIV_BUSY, PC_SWAIT};
      PC_STEST:  w = '{OP_NOP,   C_REM_Z,    PC_STRIP};
      PC_SCALE:  w = '{OP_SCALE, C_NEVER,    PC_WAIT};
      PC_ADV:    w = '{OP_ADV,   C_ALWAYS,   PC_DSTART};
      PC_FINAL:  w = '{OP_FINAL, C_ALWAYS,   PC_EMIT};
      PC_EMIT:   w = '{OP_EMIT,  C_OUT_FULL, PC_EMIT};
      default:   w = '{OP_NOP,   C_ALWAYS,   PC_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ----- src/divisor_count_less_one_top.sv -----
// Divisor counter: microcoded trial-division sequencer with a shared bit-serial divider.
//
// Input channel: number with in_valid / in_stall. A request is taken when
// in_valid is high and in_stall is low. in_stall is high from the cycle
// after a request is taken until the sequencer returns to its wait step.
// Output channel: divisors_minus_one with out_valid / out_stall, held in an
// output register. The next request is taken while a result still waits.
// Each request runs 2 then 3, 5, 7 and so on through a restoring divider that
// yields one quotient bit per cycle; every candidate takes a trial division,
// and every prime factor stripped takes a further division.
// A zero number gives a result of zero.
// Reset returns the sequencer to its wait step and drops any held result.
// While out_stall is high the result stays put; the sequencer holds at its
// emit step only when a new result is ready and the register is still full.
module divisor_count_less_one_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dcl_pkg::NUMBER_WIDTH-1:0] number,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dcl_pkg::COUNT_W-1:0]    divisors_minus_one
);
  import dcl_pkg::*;

  pc_t                    pc;
  pc_t                    pc_next;
  uword_t                 uw;
  logic [NUMBER_WIDTH-1:0] rest;
  logic [NUMBER_WIDTH-1:0] d;
  logic [EXP_W-1:0]       e;
  logic [PROD_W-1:0]      prod;
  logic [NUMBER_WIDTH-1:0] quo;
  logic [NUMBER_WIDTH-1:0] rem;
  logic [CNT_W-1:0]       cnt;

  logic [NUMBER_WIDTH:0]  shifted;
  logic [NUMBER_WIDTH:0]  diff;
  logic                   fits;
  logic [EXP_W-1:0]       factor;
  logic [MUL_W-1:0]       mul;
  logic [PROD_W-1:0]      prod_sat;
  logic                   d_is_two;
  logic                   out_full;
  logic                   jump;

  assign uw       = ucode(pc);
  assign in_stall = (pc != PC_WAIT);
  assign d_is_two = (d == NUMBER_WIDTH'(2));
  assign out_full = out_valid && out_stall;

  assign shifted = {rem, quo[NUMBER_WIDTH-1]};
  assign diff    = shifted - {1'b0, d};
  assign fits    = (shifted >= {1'b0, d});

  assign factor   = (uw.op == OP_SCALE) ? e + EXP_W'(1) : EXP_W'(2);
  assign mul      = MUL_W'(prod) * MUL_W'(factor);
  assign prod_sat = (mul > MUL_W'(PROD_CAP)) ? PROD_CAP : mul[PROD_W-1:0];

  always_comb begin
    case (uw.cond)
      C_NEVER:    jump = 1'b0;
      C_ALWAYS:   jump = 1'b1;
      C_NO_IN:    jump = !in_valid;
      C_DIV_BUSY: jump = (cnt != '0);
      C_BEYOND:   jump = !d_is_two && (d > quo);
      C_REM_NZ:   jump = (rem != '0);
      C_REM_Z:    jump = (rem == '0);
      C_OUT_FULL: jump = out_full;
      default:    jump = 1'b0;
    endcase
    pc_next = jump ? uw.target : pc + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= PC_WAIT;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      pc <= pc_next;
      if (uw.op == OP_EMIT && !out_full) begin
        out_valid          <= 1'b1;
        divisors_minus_one <= COUNT_W'(prod - PROD_W'(1));
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cnt != '0) begin
        rem <= fits ? diff[NUMBER_WIDTH-1:0] : shifted[NUMBER_WIDTH-1:0];
        quo <= {quo[NUMBER_WIDTH-2:0], fits};
        cnt <= cnt - CNT_W'(1);
      end
      case (uw.op)
        OP_LOAD: begin
          if (in_valid) begin
            rest <= (number == '0) ? NUMBER_WIDTH'(1) : number;
            d    <= NUMBER_WIDTH'(2);
            e    <= '0;
            prod <= PROD_W'(1);
          end
        end
        OP_DIV: begin
          quo <= rest;
          rem <= '0;
          cnt <= CNT_W'(NUMBER_WIDTH);
        end
        OP_STRIP: begin
          rest <= quo;
          e    <= e + EXP_W'(1);
        end
        OP_SCALE: begin
          prod <= prod_sat;
          e    <= '0;
        end
        OP_ADV: begin
          d <= d_is_two ? NUMBER_WIDTH'(3) : d + NUMBER_WIDTH'(2);
        end
        OP_FINAL: begin
          if (rest > NUMBER_WIDTH'(1)) begin
            prod <= prod_sat;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/dcl_chk.sv -----
// Port-level checker for the divisor counter and its bind to the top level.
module dcl_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [dcl_pkg::NUMBER_WIDTH-1:0] number,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [dcl_pkg::COUNT_W-1:0]    divisors_minus_one
);
  import dcl_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(divisors_minus_one))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken but block not busy");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in progress");

endmodule

bind divisor_count_less_one_top dcl_chk u_dcl_chk (.*);
